// File: design/lobb_pkg.sv
`timescale 1ns / 1ps
package lobb_pkg;

    localparam int PRICE_LEVELS = 4096;
    localparam int ORDER_SLOTS  = 1024;
    localparam int PL_W         = $clog2(PRICE_LEVELS);
    localparam int SLOT_W       = $clog2(ORDER_SLOTS);
    localparam int CNT_W        = SLOT_W + 1;
    localparam int LVL_AW       = PL_W + 1;
    localparam int LVL_DEPTH    = 2 * PRICE_LEVELS;
    localparam int SHARE_W      = 48;
    localparam int REF_W        = 64;
    localparam int PX_IN_W      = 32;
    localparam int QTY_W        = 32;

    localparam logic [2:0] FN_ADD     = 3'd0;
    localparam logic [2:0] FN_EXEC    = 3'd1;
    localparam logic [2:0] FN_CANCEL  = 3'd2;
    localparam logic [2:0] FN_DELETE  = 3'd3;
    localparam logic [2:0] FN_REPLACE = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_DUP     = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic [REF_W-1:0]   ord_id;
        logic [REF_W-1:0]   new_ref;
        logic               side;
        logic [PX_IN_W-1:0] price;
        logic [QTY_W-1:0]   shares;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic               bid_valid;
        logic [11:0]        bid_px;
        logic [SHARE_W-1:0] bid_qty;
        logic               ask_valid;
        logic [11:0]        ask_px;
        logic [SHARE_W-1:0] ask_qty;
        logic [10:0]        live_orders;
    } t_out_item;

    typedef struct packed {
        logic [REF_W-1:0] oref;
        logic             side;
        logic [PL_W-1:0]  price;
        logic [QTY_W-1:0] shares;
    } t_order;

    typedef struct packed {
        logic [SHARE_W-1:0] shares;
        logic [CNT_W-1:0]   orders;
    } t_level;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_IDLE, OP_ACHK, OP_SRD, OP_SCMP, OP_LRD, OP_LUPD_DROP,
        OP_MRD, OP_MWR, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_CK, OP_AWR, OP_LUPD_ADD,
        OP_REP_B, OP_REP_A, OP_REP_W, OP_FIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       set_st;
        logic [2:0] st_val;
    } t_cmd;

    typedef struct packed {
        logic       in_fire;
        logic       clr_last;
        logic [2:0] func;
        logic       price_ok;
        logic       cnt_zero;
        logic       full;
        logic       hit;
        logic       idx_last;
        logic       drop;
        logic       hit_last;
        logic       rescan;
        logic       scan_none;
        logic       scan_stop;
        logic       out_free;
    } t_stat;

endpackage

// File: design/lobb_if.sv
`timescale 1ns / 1ps
interface lobb_in_if import lobb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface lobb_out_if import lobb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: design/lobb_ram.sv
`timescale 1ns / 1ps
module lobb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/lobb_ctrl.sv
`timescale 1ns / 1ps
module lobb_ctrl import lobb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_st,
    output t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_ACHK, S_SRD, S_SCMP, S_LRD, S_LUPD, S_MRD, S_MWR,
        S_POST, S_RSC0, S_RSRD, S_RSCK, S_AWR, S_ALRD, S_ALUPD, S_REPB, S_REPA,
        S_REPW, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_adding, n_adding;

    always_comb begin
        n_state       = r_state;
        n_adding      = r_adding;
        o_cmd.op      = OP_NONE;
        o_cmd.set_st  = 1'b0;
        o_cmd.st_val  = ST_OK;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.op = OP_IDLE;
                if (i_st.in_fire) begin
                    n_state  = S_DISP;
                    n_adding = 1'b0;
                end
            end
            S_DISP: begin
                case (i_st.func)
                    FN_ADD: n_state = S_ACHK;
                    FN_EXEC, FN_CANCEL, FN_DELETE, FN_REPLACE: begin
                        if (i_st.cnt_zero) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st_val = ST_UNKNOWN;
                            n_state      = S_REPB;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                    default: n_state = S_REPB;
                endcase
            end
            S_ACHK: begin
                o_cmd.op = OP_ACHK;
                n_adding = 1'b1;
                if (!i_st.price_ok) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_val = ST_RANGE;
                    n_state      = S_REPB;
                end else if (i_st.cnt_zero) begin
                    n_state = S_AWR;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.op = OP_SRD;
                n_state  = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.op = OP_SCMP;
                if (i_st.hit) begin
                    if (r_adding) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st_val = ST_DUP;
                        n_state      = S_REPB;
                    end else begin
                        n_state = S_LRD;
                    end
                end else if (i_st.idx_last) begin
                    if (!r_adding) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st_val = ST_UNKNOWN;
                        n_state      = S_REPB;
                    end else if (i_st.full) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st_val = ST_FULL;
                        n_state      = S_REPB;
                    end else begin
                        n_state = S_AWR;
                    end
                end else begin
                    n_state = S_SRD;
                end
            end
            S_LRD: begin
                o_cmd.op = OP_LRD;
                n_state  = S_LUPD;
            end
            S_LUPD: begin
                o_cmd.op = OP_LUPD_DROP;
                n_state  = i_st.drop ? S_MRD : S_REPB;
            end
            S_MRD: begin
                o_cmd.op = OP_MRD;
                n_state  = i_st.hit_last ? S_POST : S_MWR;
            end
            S_MWR: begin
                o_cmd.op = OP_MWR;
                n_state  = S_POST;
            end
            S_POST: begin
                if (i_st.rescan) n_state = S_RSC0;
                else if (i_st.func == FN_REPLACE) n_state = S_ACHK;
                else n_state = S_REPB;
            end
            S_RSC0: begin
                o_cmd.op = OP_SCAN_INIT;
                n_state  = i_st.scan_none ? S_POST : S_RSRD;
            end
            S_RSRD: begin
                o_cmd.op = OP_SCAN_RD;
                n_state  = S_RSCK;
            end
            S_RSCK: begin
                o_cmd.op = OP_SCAN_CK;
                n_state  = i_st.scan_stop ? S_POST : S_RSRD;
            end
            S_AWR: begin
                o_cmd.op = OP_AWR;
                n_state  = S_ALRD;
            end
            S_ALRD: begin
                o_cmd.op = OP_LRD;
                n_state  = S_ALUPD;
            end
            S_ALUPD: begin
                o_cmd.op = OP_LUPD_ADD;
                n_state  = S_REPB;
            end
            S_REPB: begin
                o_cmd.op = OP_REP_B;
                n_state  = S_REPA;
            end
            S_REPA: begin
                o_cmd.op = OP_REP_A;
                n_state  = S_REPW;
            end
            S_REPW: begin
                o_cmd.op = OP_REP_W;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_adding <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_adding <= n_adding;
        end
    end
endmodule

// File: design/lobb_dpath.sv
`timescale 1ns / 1ps
module lobb_dpath import lobb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_st,
    lobb_in_if.sink           i_in,
    lobb_out_if.source        o_out
);
    localparam logic [PL_W-1:0] PX_TOP = PL_W'(PRICE_LEVELS - 1);
    localparam logic [PL_W:0]   NO_ASK = (PL_W + 1)'(PRICE_LEVELS);

    logic [2:0]         r_func;
    logic [REF_W-1:0]   r_key, r_new_ref;
    logic               r_side;
    logic [PX_IN_W-1:0] r_price;
    logic [QTY_W-1:0]   r_shares;
    logic [2:0]         r_status;
    t_order             r_ord;
    logic [SLOT_W-1:0]  r_idx, r_hit;
    logic [CNT_W-1:0]   r_count;
    logic [LVL_AW-1:0]  r_lidx;
    logic [PL_W-1:0]    r_q, r_best_bid;
    logic [PL_W:0]      r_best_ask;
    logic               r_rescan;
    logic [SHARE_W-1:0] r_bid_sz, r_ask_sz;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               tb_we, lv_we;
    logic [SLOT_W-1:0]  tb_waddr, tb_raddr;
    t_order             tb_wdata, tb_rdata, new_ord;
    logic [LVL_AW-1:0]  lv_waddr, lv_raddr, ord_laddr;
    t_level             lv_wdata, lv_rdata;

    logic               fire, trim, drop, emptied, is_best, scan_hit;
    logic [QTY_W-1:0]   cut, rem;
    logic [SHARE_W-1:0] lv_sub, lv_sat;
    logic [SHARE_W:0]   lv_sum;
    logic [CNT_W-1:0]   ord_dec, idx_nx;

    lobb_ram #(.WIDTH($bits(t_order)), .DEPTH(ORDER_SLOTS)) u_table (
        .i_clk(i_clk), .i_we(tb_we), .i_waddr(tb_waddr), .i_wdata(tb_wdata),
        .i_raddr(tb_raddr), .o_rdata(tb_rdata)
    );

    lobb_ram #(.WIDTH($bits(t_level)), .DEPTH(LVL_DEPTH)) u_level (
        .i_clk(i_clk), .i_we(lv_we), .i_waddr(lv_waddr), .i_wdata(lv_wdata),
        .i_raddr(lv_raddr), .o_rdata(lv_rdata)
    );

    assign i_in.ready  = (i_cmd.op == OP_IDLE);
    assign fire        = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign trim      = (r_func == FN_EXEC) || (r_func == FN_CANCEL);
    assign cut       = !trim ? r_ord.shares :
                       (r_ord.shares < r_shares) ? r_ord.shares : r_shares;
    assign rem       = r_ord.shares - cut;
    assign drop      = (rem == '0);
    assign lv_sub    = (lv_rdata.shares > SHARE_W'(cut)) ?
                       lv_rdata.shares - SHARE_W'(cut) : '0;
    assign ord_dec   = (lv_rdata.orders != '0) ? lv_rdata.orders - CNT_W'(1) : '0;
    assign emptied   = (ord_dec == '0);
    assign is_best   = r_ord.side ? ({1'b0, r_ord.price} == r_best_ask)
                                  : (r_ord.price == r_best_bid);
    assign lv_sum    = {1'b0, lv_rdata.shares} + (SHARE_W + 1)'(r_ord.shares);
    assign lv_sat    = lv_sum[SHARE_W] ? '1 : lv_sum[SHARE_W-1:0];
    assign ord_laddr = {r_ord.side, r_ord.price};
    assign scan_hit  = (lv_rdata.orders != '0);
    assign idx_nx    = {1'b0, r_idx} + CNT_W'(1);
    assign new_ord   = '{oref: r_key, side: r_side, price: r_price[PL_W-1:0],
                         shares: r_shares};

    always_comb begin
        o_st.in_fire   = fire;
        o_st.clr_last  = (r_lidx == LVL_AW'(LVL_DEPTH - 1));
        o_st.func      = r_func;
        o_st.price_ok  = (r_price[PX_IN_W-1:PL_W] == '0);
        o_st.cnt_zero  = (r_count == '0);
        o_st.full      = (r_count == CNT_W'(ORDER_SLOTS));
        o_st.hit       = (tb_rdata.oref == r_key);
        o_st.idx_last  = (idx_nx == r_count);
        o_st.drop      = drop;
        o_st.hit_last  = ({1'b0, r_hit} == r_count);
        o_st.rescan    = r_rescan;
        o_st.scan_none = r_ord.side ? (r_ord.price == PX_TOP)
                                    : (r_ord.price <= PL_W'(1));
        o_st.scan_stop = scan_hit || (r_ord.side ? (r_q == PX_TOP) : (r_q == PL_W'(1)));
        o_st.out_free  = !r_out_valid || o_out.ready;
    end

    always_comb begin
        tb_we    = 1'b0;
        tb_waddr = r_hit;
        tb_wdata = tb_rdata;
        tb_raddr = r_idx;
        lv_we    = 1'b0;
        lv_waddr = ord_laddr;
        lv_wdata = '0;
        lv_raddr = ord_laddr;
        case (i_cmd.op)
            OP_CLR: begin
                lv_we    = 1'b1;
                lv_waddr = r_lidx;
            end
            OP_LUPD_DROP: begin
                lv_we           = 1'b1;
                lv_wdata.orders = drop ? ord_dec : lv_rdata.orders;
                lv_wdata.shares = (drop && emptied) ? '0 : lv_sub;
                tb_we           = !drop;
                tb_wdata        = r_ord;
                tb_wdata.shares = rem;
            end
            OP_MRD:     tb_raddr = r_count[SLOT_W-1:0];
            OP_MWR:     tb_we    = 1'b1;
            OP_SCAN_RD: lv_raddr = {r_ord.side, r_q};
            OP_AWR: begin
                tb_we    = 1'b1;
                tb_waddr = r_count[SLOT_W-1:0];
                tb_wdata = new_ord;
            end
            OP_LUPD_ADD: begin
                lv_we           = 1'b1;
                lv_wdata.shares = lv_sat;
                lv_wdata.orders = lv_rdata.orders + CNT_W'(1);
            end
            OP_REP_B: lv_raddr = {1'b0, r_best_bid};
            OP_REP_A: lv_raddr = {1'b1, r_best_ask[PL_W-1:0]};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lidx      <= '0;
            r_best_bid  <= '0;
            r_best_ask  <= NO_ASK;
            r_count     <= '0;
            r_rescan    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((i_cmd.op == OP_FIN) && o_st.out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.set_st) r_status <= i_cmd.st_val;
            case (i_cmd.op)
                OP_CLR: r_lidx <= r_lidx + LVL_AW'(1);
                OP_IDLE: begin
                    if (fire) begin
                        r_func    <= i_in.data.func;
                        r_key     <= i_in.data.ord_id;
                        r_new_ref <= i_in.data.new_ref;
                        r_side    <= i_in.data.side;
                        r_price   <= i_in.data.price;
                        r_shares  <= i_in.data.shares;
                        r_status  <= ST_OK;
                        r_idx     <= '0;
                    end
                end
                OP_ACHK: begin
                    r_idx <= '0;
                    if (r_func == FN_REPLACE) begin
                        r_key  <= r_new_ref;
                        r_side <= r_ord.side;
                    end
                end
                OP_SCMP: begin
                    if (o_st.hit) begin
                        r_ord <= tb_rdata;
                        r_hit <= r_idx;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                OP_LUPD_DROP: begin
                    if (drop) begin
                        r_count  <= r_count - CNT_W'(1);
                        r_rescan <= emptied && is_best;
                    end
                end
                OP_SCAN_INIT: begin
                    r_rescan <= 1'b0;
                    if (r_ord.side) begin
                        if (o_st.scan_none) r_best_ask <= NO_ASK;
                        else r_q <= r_ord.price + PL_W'(1);
                    end else begin
                        if (o_st.scan_none) r_best_bid <= '0;
                        else r_q <= r_ord.price - PL_W'(1);
                    end
                end
                OP_SCAN_CK: begin
                    if (scan_hit) begin
                        if (r_ord.side) r_best_ask <= {1'b0, r_q};
                        else r_best_bid <= r_q;
                    end else if (o_st.scan_stop) begin
                        if (r_ord.side) r_best_ask <= NO_ASK;
                        else r_best_bid <= '0;
                    end else begin
                        r_q <= r_ord.side ? r_q + PL_W'(1) : r_q - PL_W'(1);
                    end
                end
                OP_AWR: begin
                    r_ord   <= new_ord;
                    r_count <= r_count + CNT_W'(1);
                end
                OP_LUPD_ADD: begin
                    if (!r_ord.side && (r_ord.price > r_best_bid)) r_best_bid <= r_ord.price;
                    if (r_ord.side && ({1'b0, r_ord.price} < r_best_ask)) begin
                        r_best_ask <= {1'b0, r_ord.price};
                    end
                end
                OP_REP_A: r_bid_sz <= (r_best_bid != '0) ? lv_rdata.shares : '0;
                OP_REP_W: r_ask_sz <= !r_best_ask[PL_W] ? lv_rdata.shares : '0;
                OP_FIN: begin
                    if (o_st.out_free) begin
                        r_out.status      <= r_status;
                        r_out.bid_valid   <= (r_best_bid != '0);
                        r_out.bid_px      <= 12'(r_best_bid);
                        r_out.bid_qty     <= r_bid_sz;
                        r_out.ask_valid   <= !r_best_ask[PL_W];
                        r_out.ask_px      <= r_best_ask[PL_W] ? 12'd0 : 12'(r_best_ask);
                        r_out.ask_qty     <= r_ask_sz;
                        r_out.live_orders <= 11'(r_count);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: design/limit_order_book_bbo_core.sv
// Per message: an unused kind or a lookup in an empty table goes straight to the report; a
// search compares stored orders in turn; a kept order is trimmed in place; a removed order is
// replaced by the last stored one; a best-level rescan reads levels in turn; insert appends.
// Replace removes then inserts. The result is registered in the last cycle of the message.
// Throughput: one message at a time; the last cycle holds while the output register is full.
// Reset: synchronous, active low; all 8192 level entries are then cleared, with no input transfer.
`timescale 1ns / 1ps
module limit_order_book_bbo_core import lobb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lobb_in_if.sink    i_in,
    lobb_out_if.source o_out
);
    t_cmd  cmd;
    t_stat st;

    lobb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_st(st), .o_cmd(cmd)
    );

    lobb_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_st(st),
        .i_in(i_in), .o_out(o_out)
    );
endmodule
